/* src/msnco_pkg.sv */
// ----------------------------------------------------------------------------
// msnco_pkg: shared types and constants of the MIDI overridable sine NCO
// Field widths, item kind codes, saturation limits, the step register reset
// value and the equal-temperament note frequency ROM.
// ----------------------------------------------------------------------------
package msnco_pkg;

    // Field widths of the transaction payloads.
    localparam int KIND_W  = 2;
    localparam int FREQ_W  = 23;
    localparam int AMP_W   = 17;
    localparam int PITCH_W = 7;
    localparam int STEP_W  = 28;

    // Output sample width and the full-scale value of the sine table.
    localparam int SAMPLE_BITS = 16;
    localparam longint unsigned FULL_SCALE = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    // Item kind codes.
    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd2;

    // Saturation limits: 20000 Hz in Q8 and a gain of 1.0 in Q0.16.
    localparam logic [FREQ_W-1:0] FREQ_MAX = 23'd5120000;
    localparam logic [AMP_W-1:0]  AMP_MAX  = 17'd65536;

    // The step register is 2^40 / sample rate, reset for 44100 Hz.
    localparam logic [STEP_W-1:0] STEP_RESET = 28'd24932236;

    // The product frequency * step carries 48 fraction bits of a cycle.
    localparam int INCR_FRAC_BITS = 48;

    // Fraction bits of the Q0.16 amplitude product, also used for its rounding offset.
    localparam int AMP_FRAC_BITS = 16;

    // pi / 2 in Q30, used to build the sine table.
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Note override state handed to the phase step logic.
    typedef struct packed {
        logic               active;
        logic [PITCH_W-1:0] pitch;
    } override_t;

    // Octave 4 (notes 60 to 71) equal-temperament frequencies in Q16.
    localparam int NOTE_COUNT = 1 << PITCH_W;
    localparam logic [24:0] OCTAVE4_Q16 [12] = '{
        25'd17145893, 25'd18165441, 25'd19245614, 25'd20390018,
        25'd21602472, 25'd22887021, 25'd24247954, 25'd25689813,
        25'd27217409, 25'd28835840, 25'd30550508, 25'd32367136
    };

    typedef logic [FREQ_W-1:0] note_rom_t [NOTE_COUNT];

    // Shift the octave 4 value by the note's octave, then round from Q21 to Q8.
    function automatic note_rom_t build_note_rom();
        note_rom_t       rom;
        longint unsigned v;
        for (int n = 0; n < NOTE_COUNT; n++)
        begin
            v = (longint'(OCTAVE4_Q16[n % 12]) << (n / 12)) + 64'd4096;
            v = v >> 13;
            if (v > longint'(FREQ_MAX))
            begin
                v = longint'(FREQ_MAX);
            end
            rom[n] = FREQ_W'(v);
        end
        return rom;
    endfunction

    localparam note_rom_t NOTE_FREQ_ROM = build_note_rom();

endpackage

/* src/msnco_phase_step.sv */
// ----------------------------------------------------------------------------
// msnco_phase_step: phase increment of one sample tick
// Selects the saturated tick frequency or the note ROM frequency and scales it
// by the step register to a phase increment.
// ----------------------------------------------------------------------------
module msnco_phase_step #(
    parameter int PHASE_BITS = 32
) (
    input  msnco_pkg::override_t           override_state,
    input  logic [msnco_pkg::FREQ_W-1:0]   frequency,
    input  logic [msnco_pkg::STEP_W-1:0]   phase_step_per_hz,
    output logic [PHASE_BITS-1:0]          increment
);
    import msnco_pkg::*;

    localparam int PRODUCT_W = FREQ_W + STEP_W;
    localparam int SHIFT     = INCR_FRAC_BITS - PHASE_BITS;

    logic [FREQ_W-1:0]    freq_sat;
    logic [FREQ_W-1:0]    freq_sel;
    logic [PRODUCT_W-1:0] product;

    assign freq_sat  = (frequency > FREQ_MAX) ? FREQ_MAX : frequency;
    assign freq_sel  = override_state.active ? NOTE_FREQ_ROM[override_state.pitch] : freq_sat;
    assign product   = PRODUCT_W'(freq_sel) * PRODUCT_W'(phase_step_per_hz);
    // The low fraction bits below the phase resolution are dropped.
    assign increment = product[SHIFT +: PHASE_BITS];

endmodule

/* src/msnco_sine_lookup.sv */
// ----------------------------------------------------------------------------
// msnco_sine_lookup: quarter-wave sine table and amplitude scaling
// Folds the top phase bits onto a quarter-wave table, scales the entry by the
// saturated amplitude and restores the sign of the half cycle.
// ----------------------------------------------------------------------------
module msnco_sine_lookup #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic [SINE_TABLE_BITS-1:0]          phase_top,
    input  logic [msnco_pkg::AMP_W-1:0]         amplitude,
    output logic [msnco_pkg::SAMPLE_BITS-1:0]   sample
);
    import msnco_pkg::*;

    localparam int QUARTER   = 1 << (SINE_TABLE_BITS - 2);
    localparam int IDX_W     = SINE_TABLE_BITS - 1;
    localparam int ENTRY_W   = SAMPLE_BITS - 1;
    localparam int PRODUCT_W = AMP_W + ENTRY_W + 1;

    // Series numerators stay below 2^34, so a 40-bit quotient covers them.
    localparam int SERIES_DIV_BITS = 40;

    typedef logic [ENTRY_W-1:0] entry_t;
    typedef entry_t sine_rom_t [QUARTER + 1];

    // Shift-subtract quotient used for the series divisors.
    function automatic longint unsigned series_quotient(
        input longint unsigned num,
        input longint unsigned den
    );
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = SERIES_DIV_BITS - 1; b >= 0; b--)
        begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // Entry i holds round(sin(i * pi / (2 * QUARTER)) * FULL_SCALE), with the
    // sine taken from a Q30 integer Taylor series.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t       rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned k;
        longint unsigned s;
        longint          sum;
        logic            neg;
        for (int i = 0; i <= QUARTER; i++)
        begin
            x    = (longint'(i) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            k    = 64'd1;
            neg  = 1'b1;
            for (int j = 0; j < 20; j++)
            begin
                if (term != 64'd0)
                begin
                    term = (term * x2) >> 30;
                    term = series_quotient(term, (k + 64'd1) * (k + 64'd2));
                    k    = k + 64'd2;
                    sum  = neg ? sum - longint'(term) : sum + longint'(term);
                    neg  = !neg;
                end
            end
            s = (sum < 0) ? 64'd0 : longint'(sum);
            s = (s * FULL_SCALE + (64'd1 << 29)) >> 30;
            if (s > FULL_SCALE)
            begin
                s = FULL_SCALE;
            end
            rom[i] = ENTRY_W'(s);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    logic [1:0]             quadrant;
    logic [IDX_W-1:0]       idx;
    logic [AMP_W-1:0]       amp_sat;
    entry_t                 entry;
    logic [PRODUCT_W-1:0]   product;
    logic [ENTRY_W-1:0]     magnitude;

    assign quadrant = phase_top[SINE_TABLE_BITS-1 -: 2];
    // Odd quadrants run the table backwards, starting on the peak entry.
    assign idx = quadrant[0]
               ? (IDX_W'(QUARTER) - {1'b0, phase_top[SINE_TABLE_BITS-3:0]})
               : {1'b0, phase_top[SINE_TABLE_BITS-3:0]};
    assign entry     = SINE_ROM[idx];
    assign amp_sat   = (amplitude > AMP_MAX) ? AMP_MAX : amplitude;
    assign product   = PRODUCT_W'(amp_sat) * PRODUCT_W'(entry)
                     + (PRODUCT_W'(1) << (AMP_FRAC_BITS - 1));
    assign magnitude = product[AMP_FRAC_BITS +: ENTRY_W];
    // A zero magnitude negates to zero, so no negative zero can appear.
    assign sample = quadrant[1] ? (-{1'b0, magnitude}) : {1'b0, magnitude};

endmodule

/* src/midi_overridable_sine_nco_top.sv */
// ----------------------------------------------------------------------------
// midi_overridable_sine_nco_top: sine oscillator with a MIDI note override
// Phase accumulator oscillator driven by sample ticks, whose frequency can be
// replaced by the equal-temperament pitch of the last note-on.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_ready) carries one item per transaction:
// a sample tick, a note-on or a note-off, selected by kind. A note-on stores
// its pitch and switches the oscillator to that note; a note-off returns it
// to the tick frequency. Notes and the unused kind code give no output.
// Every tick gives one transaction on the output channel (out_valid /
// out_ready): amplitude times the sine of the current phase. The phase then
// advances by the selected frequency times phase_step_per_hz.
// A tick accepted into the input register moves on to the result register
// once that register has room, and is then presented on sample_value.
// Throughput is one item per cycle while the receiver keeps up; the input
// register, with one multiplier on the phase path and one on the sample
// path, sets that figure.
// The input stays ready while a result waits, as long as the input register
// can drain; a stalled receiver holds one result and one tick, then in_ready
// drops. phase_step_per_hz is written through cfg_write_en / cfg_write_data;
// the user writes it only while the block is idle, which is not enforced. Reset
// clears phase, override, both valid flags, and sets the step for 44100 Hz.
// ----------------------------------------------------------------------------
module midi_overridable_sine_nco_top #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write_en,
    input  logic [msnco_pkg::STEP_W-1:0]            cfg_write_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [msnco_pkg::KIND_W-1:0]            kind,
    input  logic [msnco_pkg::FREQ_W-1:0]            frequency,
    input  logic [msnco_pkg::AMP_W-1:0]             amplitude,
    input  logic [msnco_pkg::PITCH_W-1:0]           pitch,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [msnco_pkg::SAMPLE_BITS-1:0]       sample_value
);
    import msnco_pkg::*;

    // Input register: one item waiting to be processed.
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [KIND_W-1:0]      s1_kind_reg;
    logic [FREQ_W-1:0]      s1_freq_reg;
    logic [AMP_W-1:0]       s1_amp_reg;
    logic [PITCH_W-1:0]     s1_pitch_reg;

    // Oscillator state and the configuration register.
    logic [PHASE_BITS-1:0]  phase_reg;
    logic [PHASE_BITS-1:0]  phase_next;
    override_t              override_reg;
    override_t              override_next;
    logic [STEP_W-1:0]      step_reg;

    // Result register.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SAMPLE_BITS-1:0] sample_reg;

    logic                   in_accept;
    logic                   out_free;
    logic                   s1_tick;
    logic                   s1_advance;
    logic [PHASE_BITS-1:0]  increment;
    logic [SAMPLE_BITS-1:0] sample;

    // A note item leaves the input register at once; a tick needs room in
    // the result register, which frees up in the same cycle it is taken.
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_tick    = (s1_kind_reg == KIND_TICK);
    assign s1_advance = s1_valid_reg && (!s1_tick || out_free);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    msnco_phase_step #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase_step (
        .override_state    (override_reg),
        .frequency         (s1_freq_reg),
        .phase_step_per_hz (step_reg),
        .increment         (increment)
    );

    msnco_sine_lookup #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_lookup (
        .phase_top (phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS]),
        .amplitude (s1_amp_reg),
        .sample    (sample)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // The item in the input register updates the state when it leaves.
    always_comb
    begin
        phase_next    = phase_reg;
        override_next = override_reg;
        if (s1_advance)
        begin
            unique case (s1_kind_reg)
                KIND_TICK:
                begin
                    phase_next = phase_reg + increment;
                end
                KIND_NOTE_ON:
                begin
                    override_next.active = 1'b1;
                    override_next.pitch  = s1_pitch_reg;
                end
                KIND_NOTE_OFF:
                begin
                    override_next.active = 1'b0;
                end
                default:
                begin
                    // The unused kind code is dropped without effect.
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance && s1_tick)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            override_reg  <= '0;
            step_reg      <= STEP_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            override_reg  <= override_next;
            if (cfg_write_en)
            begin
                step_reg <= cfg_write_data;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg  <= kind;
            s1_freq_reg  <= frequency;
            s1_amp_reg   <= amplitude;
            s1_pitch_reg <= pitch;
        end
        if (s1_advance && s1_tick)
        begin
            sample_reg <= sample;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = sample_reg;

endmodule

/* src/msnco_checker.sv */
// ----------------------------------------------------------------------------
// msnco_checker: port-level assertions for the sine NCO
// Watches the top level's handshakes and output samples over time, attached
// to the top level by a bind statement.
// ----------------------------------------------------------------------------
module msnco_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [msnco_pkg::SAMPLE_BITS-1:0]   sample_value
);
    import msnco_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] MOST_NEGATIVE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // A result that is not taken stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_value))
        else $error("stalled output transaction changed or vanished");

    // Reset leaves no output transaction pending.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // With the receiver ready the input register always drains.
    assert property (@(posedge clk) out_ready |-> in_ready)
        else $error("input stalled while the receiver is ready");

    // Samples are symmetric, so the most negative code never appears.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_value != MOST_NEGATIVE)
        else $error("sample out of symmetric range");

endmodule

bind midi_overridable_sine_nco_top msnco_checker u_msnco_checker (.*);
